// ===== src/cgl_pkg.sv =====
// Shared types, sizes and codes for the color gradient lookup block.
// No dependencies; every other file of the block imports this package.
package cgl_pkg;

    localparam int MAX_STOPS = 8;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);
    localparam int POS_W     = 16;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 4 * CH_W;
    localparam int DIFF_W    = POS_W;             // x1-x0, x1-v, v-x0 are all below 2^16
    localparam int PROD_W    = CH_W + DIFF_W;     // y*a and the sum y0*a + y1*b
    localparam int NUM_W     = PROD_W + 1;        // 2*t + d
    localparam int DEN_W     = DIFF_W + 1;        // 2*d
    localparam int SH_W      = DEN_W + CH_W - 1;  // divisor aligned to the top quotient bit
    localparam int STEP_W    = $clog2(CH_W);

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                    action;
        logic signed [POS_W-1:0] stop_position;
        logic signed [POS_W-1:0] lookup_value;
        logic [CH_W-1:0]         stop_red;
        logic [CH_W-1:0]         stop_green;
        logic [CH_W-1:0]         stop_blue;
        logic [CH_W-1:0]         stop_alpha;
    } t_in_item;

    typedef struct packed {
        t_status         status;
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_result;

    // One table row: position and RGBA color (red in the low byte).
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [COLOR_W-1:0]      color;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_MUL_A,
        S_MUL_B,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== src/cgl_stop_ram.sv =====
// Stop table storage: one write port, one read port with registered data.
// Depends on cgl_pkg for the row type and depth.
module cgl_stop_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [cgl_pkg::IDX_W-1:0] i_waddr,
    input  cgl_pkg::t_entry           i_wdata,
    input  logic [cgl_pkg::IDX_W-1:0] i_raddr,
    output cgl_pkg::t_entry           o_rdata
);
    import cgl_pkg::*;

    t_entry r_mem [MAX_STOPS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cgl_div.sv =====
// Restoring divider, one quotient bit per cycle, for an 8-bit quotient.
// Depends on cgl_pkg for widths and the request struct.
module cgl_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cgl_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [cgl_pkg::CH_W-1:0] o_quot
);
    import cgl_pkg::*;

    logic [NUM_W-1:0]  r_rem,  n_rem;
    logic [SH_W-1:0]   r_dsh,  n_dsh;
    logic [CH_W-1:0]   r_q,    n_q;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_run,  n_run;
    logic              r_done, n_done;
    logic              ge;
    logic [NUM_W-1:0]  dsh_ext;

    assign dsh_ext = NUM_W'(r_dsh);
    assign ge      = (r_rem >= dsh_ext);

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_step = r_step;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.num;
            n_dsh  = {i_req.den, (CH_W-1)'(0)};
            n_q    = '0;
            n_step = '0;
            n_run  = 1'b1;
        end else if (r_run) begin
            if (ge) begin
                n_rem = r_rem - dsh_ext;
            end
            n_q    = {r_q[CH_W-2:0], ge};
            n_dsh  = r_dsh >> 1;
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(CH_W-1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_step <= n_step;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== src/color_gradient_lookup.sv =====
// An add scans the entries in order; a new position then moves each entry above its slot
//   up a row (a read, then a write) to open the slot before the new row is written.
// A lookup scans to the bracketing stop; if the value lies between two stops, each channel
//   then takes two multiply steps on one multiplier and a pass through the divider.
// Throughput: one item at a time; busy holds until the o_done beat ends. Results cannot stall.
// Reset (synchronous, active low) empties the table; table rows are not cleared.
module color_gradient_lookup (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cgl_pkg::t_in_item i_item,
    output logic              o_done,
    output cgl_pkg::t_result  o_result
);
    import cgl_pkg::*;

    t_state r_state, n_state;

    // Item latched at the accepted beat.
    logic                    r_action;
    logic signed [POS_W-1:0] r_key;       // stop position on add, lookup value on lookup
    logic [COLOR_W-1:0]      r_new_color;

    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;        // entry under compare during the scan
    logic [IDX_W-1:0]   r_k;          // destination row while shifting up
    logic [IDX_W-1:0]   r_ins;        // insertion row
    t_entry             r_prev;       // row just below r_idx
    logic [COLOR_W-1:0] r_lo_color, r_hi_color;
    logic [DIFF_W-1:0]  r_a, r_b, r_d;
    logic [1:0]         r_ch;
    logic [PROD_W-1:0]  r_acc;
    logic [COLOR_W-1:0] r_color;
    t_status            r_status;

    // Table port signals.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;

    // Shared multiplier and divider.
    t_div_req          div_req;
    logic              div_done;
    logic [CH_W-1:0]   div_quot;
    logic [CH_W-1:0]   mul_y;
    logic [DIFF_W-1:0] mul_x;
    logic [PROD_W-1:0] mul_out;
    logic [PROD_W-1:0] acc_sum;

    logic accept;
    logic scan_eq, scan_gt, scan_end, tbl_full;
    logic signed [POS_W:0] dif_a, dif_b, dif_d;

    cgl_stop_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cgl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign accept   = start && (r_state == S_IDLE);
    assign scan_eq  = (ram_rdata.pos == r_key);
    assign scan_gt  = (ram_rdata.pos > r_key);
    assign scan_end = ((CNT_W'(r_idx) + 1'b1) == r_count);
    assign tbl_full = (r_count == CNT_W'(MAX_STOPS));

    // Interval terms; the bracketing stops guarantee each is in 0..65535.
    assign dif_a = {ram_rdata.pos[POS_W-1], ram_rdata.pos} - {r_key[POS_W-1], r_key};
    assign dif_b = {r_key[POS_W-1], r_key} - {r_prev.pos[POS_W-1], r_prev.pos};
    assign dif_d = {ram_rdata.pos[POS_W-1], ram_rdata.pos}
                 - {r_prev.pos[POS_W-1], r_prev.pos};

    // One multiplier: y0*a in the first step, y1*b in the second.
    assign mul_out = PROD_W'(mul_y) * PROD_W'(mul_x);
    assign acc_sum = r_acc + mul_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_count == '0) begin
                        n_state = (i_item.action == ACT_ADD) ? S_PUT : S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_action == ACT_ADD) begin
                    if (scan_eq) begin
                        n_state = S_DONE;
                    end else if (scan_gt) begin
                        n_state = tbl_full ? S_DONE : S_SHIFT_RD;
                    end else if (scan_end) begin
                        n_state = tbl_full ? S_DONE : S_PUT;
                    end
                end else begin
                    if (scan_gt) begin
                        n_state = (r_idx == '0) ? S_DONE : S_MUL_A;
                    end else if (scan_end) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = ((r_k - 1'b1) == r_ins) ? S_PUT : S_SHIFT_RD;
            S_PUT:      n_state = S_DONE;
            S_MUL_A:    n_state = S_MUL_B;
            S_MUL_B:    n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = (r_ch == 2'd3) ? S_DONE : S_MUL_A;
                end
            end
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        busy          = (r_state != S_IDLE);
        o_done        = (r_state == S_DONE);
        ram_we        = 1'b0;
        ram_waddr     = r_idx;
        ram_wdata     = '{pos: r_key, color: r_new_color};
        ram_raddr     = '0;
        mul_y         = r_lo_color[r_ch*CH_W +: CH_W];
        mul_x         = r_a;
        div_req.start = 1'b0;
        div_req.num   = {acc_sum, 1'b0} + NUM_W'(r_d);
        div_req.den   = {r_d, 1'b0};
        unique case (r_state)
            S_SCAN: begin
                ram_raddr = r_idx + 1'b1;
                ram_we    = (r_action == ACT_ADD) && scan_eq;
            end
            S_SHIFT_RD: begin
                ram_raddr = r_k - 1'b1;
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = ram_rdata;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_ins;
            end
            S_MUL_B: begin
                mul_y         = r_hi_color[r_ch*CH_W +: CH_W];
                mul_x         = r_b;
                div_req.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PUT) begin
                r_count <= r_count + 1'b1;
            end
        end

        if (accept) begin
            r_action    <= i_item.action;
            r_key       <= (i_item.action == ACT_ADD) ? i_item.stop_position
                                                      : i_item.lookup_value;
            r_new_color <= {i_item.stop_alpha, i_item.stop_blue,
                            i_item.stop_green, i_item.stop_red};
            r_idx       <= '0;
            r_ins       <= '0;
            r_ch        <= '0;
            r_color     <= '0;
            r_status    <= (i_item.action == ACT_LOOKUP && r_count == '0) ? ST_EMPTY : ST_OK;
        end

        unique case (r_state)
            S_SCAN: begin
                // Advance past entries at or below the key; remember the lower neighbor.
                r_idx  <= r_idx + 1'b1;
                r_prev <= ram_rdata;
                r_k    <= r_count[IDX_W-1:0];
                if (r_action == ACT_ADD) begin
                    if (!scan_eq && (scan_gt || scan_end)) begin
                        if (tbl_full) begin
                            r_status <= ST_FULL;
                        end
                        r_ins <= scan_gt ? r_idx : r_count[IDX_W-1:0];
                    end
                end else begin
                    if ((scan_gt && r_idx == '0) || (!scan_gt && scan_end)) begin
                        r_color <= ram_rdata.color;
                    end
                    r_lo_color <= r_prev.color;
                    r_hi_color <= ram_rdata.color;
                    r_a        <= dif_a[DIFF_W-1:0];
                    r_b        <= dif_b[DIFF_W-1:0];
                    r_d        <= dif_d[DIFF_W-1:0];
                end
            end
            S_SHIFT_WR: begin
                r_k <= r_k - 1'b1;
            end
            S_MUL_A: begin
                r_acc <= mul_out;
            end
            S_DIV: begin
                if (div_done) begin
                    r_color[r_ch*CH_W +: CH_W] <= div_quot;
                    r_ch <= r_ch + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = '{status:    r_status,
                        out_red:   r_color[0*CH_W +: CH_W],
                        out_green: r_color[1*CH_W +: CH_W],
                        out_blue:  r_color[2*CH_W +: CH_W],
                        out_alpha: r_color[3*CH_W +: CH_W]};

    // The table never holds more rows than it has.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STOPS))
        else $error("stop count beyond table depth");

    // The count only ever grows, one row per item.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("stop count jumped");

    // A dropped stop is reported only on a full table.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> tbl_full)
        else $error("full status with room in the table");

    // Each result beat is followed by an idle cycle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after result beat");

    // The divider only reports a quotient while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule

// ===== test/gradient_checker.sv =====
`timescale 1ns / 1ps
// Checker for color_gradient_lookup: watches the command and result channels, keeps its own copy
// of the stop table, predicts every result beat and compares it field by field.
// Depends on cgl_pkg for the item and result types and the status codes.
module gradient_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  cgl_pkg::t_in_item i_item,
    input  logic              i_done,
    input  cgl_pkg::t_result  i_result,
    output int                o_fail_count,
    output int                o_pending
);
    import cgl_pkg::*;

    int          stop_pos [MAX_STOPS];
    logic [31:0] stop_rgba [MAX_STOPS];
    int          stop_total;
    t_result     expected_colors [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        stop_total   = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Round to nearest, ties up: floor((2t + d) / 2d) with d = x1 - x0 > 0.
    function automatic logic [7:0] blend_channel(input int y0, input int y1, input int x0,
                                                 input int x1, input int v);
        longint span;
        longint acc;
        span = longint'(x1) - x0;
        acc  = longint'(y0) * (x1 - v) + longint'(y1) * (v - x0);
        return 8'((2 * acc + span) / (2 * span));
    endfunction

    // Apply one command to the table copy and return the result beat it should produce.
    function automatic t_result predict_gradient(input t_in_item it);
        t_result     res;
        logic [31:0] rgba;
        int          p;
        int          v;
        int          hit;
        int          slot;
        res  = '0;
        rgba = '0;
        res.status = ST_OK;
        if (it.action == ACT_ADD) begin
            p   = int'($signed(it.stop_position));
            hit = -1;
            for (int i = 0; i < stop_total; i++) begin
                if (hit < 0 && stop_pos[i] == p) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                stop_rgba[hit] = {it.stop_alpha, it.stop_blue, it.stop_green, it.stop_red};
            end else if (stop_total >= MAX_STOPS) begin
                res.status = ST_FULL;
            end else begin
                slot = 0;
                while (slot < stop_total && stop_pos[slot] < p) slot++;
                for (int k = stop_total; k > slot; k--) begin
                    stop_pos[k]  = stop_pos[k-1];
                    stop_rgba[k] = stop_rgba[k-1];
                end
                stop_pos[slot]  = p;
                stop_rgba[slot] = {it.stop_alpha, it.stop_blue, it.stop_green, it.stop_red};
                stop_total++;
            end
        end else begin
            v = int'($signed(it.lookup_value));
            if (stop_total == 0) begin
                res.status = ST_EMPTY;
            end else begin
                slot = 0;
                while (slot < stop_total && stop_pos[slot] <= v) slot++;
                if (slot == 0) begin
                    rgba = stop_rgba[0];
                end else if (slot >= stop_total) begin
                    rgba = stop_rgba[stop_total-1];
                end else begin
                    for (int ch = 0; ch < 4; ch++) begin
                        rgba[8*ch +: 8] = blend_channel(int'(stop_rgba[slot-1][8*ch +: 8]),
                                                        int'(stop_rgba[slot][8*ch +: 8]),
                                                        stop_pos[slot-1], stop_pos[slot], v);
                    end
                end
            end
            res.out_red   = rgba[7:0];
            res.out_green = rgba[15:8];
            res.out_blue  = rgba[23:16];
            res.out_alpha = rgba[31:24];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n) begin
            if ($isunknown(i_done)) begin
                report_mismatch("done strobe unknown", 32'(i_done), 32'd0);
            end else if (i_done) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 32'(i_result), 32'd0);
                end else begin
                    want = expected_colors.pop_front();
                    if (i_result.status !== want.status)
                        report_mismatch("status", 32'(i_result.status), 32'(want.status));
                    if (i_result.out_red !== want.out_red)
                        report_mismatch("red", 32'(i_result.out_red), 32'(want.out_red));
                    if (i_result.out_green !== want.out_green)
                        report_mismatch("green", 32'(i_result.out_green), 32'(want.out_green));
                    if (i_result.out_blue !== want.out_blue)
                        report_mismatch("blue", 32'(i_result.out_blue), 32'(want.out_blue));
                    if (i_result.out_alpha !== want.out_alpha)
                        report_mismatch("alpha", 32'(i_result.out_alpha), 32'(want.out_alpha));
                end
            end
            // A command beat lands after the result of the one before it.
            if (i_start && !i_busy) begin
                expected_colors.push_back(predict_gradient(i_item));
            end
        end
        o_pending <= expected_colors.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the color_gradient_lookup testbench: clock, reset, command stimulus and verdict.
// Depends on cgl_pkg, the block itself and gradient_checker, which predicts and compares.
module tb_top;
    import cgl_pkg::*;

    // Period 10 ns; the run is far shorter than this cap, so hitting it means a hang.
    localparam int WATCHDOG_NS = 5_000_000;
    // Margin past the longest lookup, to watch for stray result beats at the end.
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 800;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_in_item i_item;
    logic     o_done;
    t_result  o_result;
    int       fail_count;
    int       pending;

    // Sorted stop positions that the directed part loads; the table is full after it,
    // so these stay the live stops for the rest of the run.
    int stop_grid [8] = '{-32768, -16'sh2000, -16'sh1000, 16'sh0800,
                          16'sh1000, 16'sh2000, 16'sh3000, 32767};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    color_gradient_lookup dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    gradient_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Fill every field with noise; callers overwrite what the command actually uses.
    function automatic t_in_item noise_item();
        t_in_item it;
        it.action        = 1'($urandom);
        it.stop_position = 16'($urandom);
        it.lookup_value  = 16'($urandom);
        it.stop_red      = 8'($urandom);
        it.stop_green    = 8'($urandom);
        it.stop_blue     = 8'($urandom);
        it.stop_alpha    = 8'($urandom);
        return it;
    endfunction

    // Add beat: the lookup value rides along as noise, since an add ignores it.
    function automatic t_in_item add_stop(input int pos, input logic [31:0] rgba);
        t_in_item it;
        it = noise_item();
        it.action        = ACT_ADD;
        it.stop_position = pos[15:0];
        {it.stop_alpha, it.stop_blue, it.stop_green, it.stop_red} = rgba;
        return it;
    endfunction

    // Lookup beat: the stop position and color fields ride along as noise.
    function automatic t_in_item color_at(input int v);
        t_in_item it;
        it = noise_item();
        it.action       = ACT_LOOKUP;
        it.lookup_value = v[15:0];
        return it;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Call at a rising edge. Hold the beat until the block takes it, then idle for the given gap;
    // with drain set, also hold off until every pending result has come back.
    // With no gap and no drain, start stays high for the caller's next beat.
    task automatic send_beat(input t_in_item it, input int gap, input bit drain);
        i_item <= it;
        start  <= 1'b1;
        @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        if (gap > 0 || drain) begin
            start  <= 1'b0;
            i_item <= noise_item();
            if (drain) begin
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
                @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Pick a lookup value: anywhere, inside one segment, right on a stop, or an extreme.
    function automatic int pick_lookup();
        int roll;
        int seg;
        roll = $urandom_range(0, 99);
        if (roll < 35) return int'($signed(16'($urandom)));
        if (roll < 80) begin
            seg = $urandom_range(0, 6);
            return stop_grid[seg] + int'($urandom_range(0, stop_grid[seg+1] - stop_grid[seg]));
        end
        if (roll < 92) return stop_grid[$urandom_range(0, 7)];
        return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    endfunction

    initial begin : stimulus
        int roll;
        int gap;
        bit drain;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Lookup on the empty table at both extremes of the value.
        send_beat(color_at(32767), pick_gap(), 1'b0);
        send_beat(color_at(-32768), pick_gap(), 1'b0);
        // Single stop: every lookup answers its color, below, on and above it.
        send_beat(add_stop(stop_grid[4], 32'hFF00_C80A), pick_gap(), 1'b0);
        send_beat(color_at(-32768), pick_gap(), 1'b0);
        send_beat(color_at(stop_grid[4]), pick_gap(), 1'b0);
        send_beat(color_at(32767), pick_gap(), 1'b0);
        // Replace the color of an existing position.
        send_beat(add_stop(stop_grid[4], 32'h0180_00FF), pick_gap(), 1'b0);
        // Insert at head, tail, middle, then at both extremes of the position range.
        send_beat(add_stop(stop_grid[2], 32'h0000_0000), pick_gap(), 1'b0);
        send_beat(add_stop(stop_grid[6], 32'hFFFF_FFFF), pick_gap(), 1'b0);
        send_beat(add_stop(stop_grid[3], 32'h7F34_CD02), pick_gap(), 1'b0);
        send_beat(add_stop(stop_grid[0], 32'hFF00_FF00), pick_gap(), 1'b0);
        send_beat(add_stop(stop_grid[7], 32'h00FF_00FF), pick_gap(), 1'b0);
        // On the first stop, on the last stop, a tie midpoint and near-boundary values.
        send_beat(color_at(-32768), pick_gap(), 1'b0);
        send_beat(color_at(32767), pick_gap(), 1'b0);
        send_beat(color_at(16'sh0C00), pick_gap(), 1'b0);
        send_beat(color_at(-1), pick_gap(), 1'b0);
        send_beat(color_at(16'sh0801), pick_gap(), 1'b0);
        // Fill the table, then try a new position (dropped) and a replace while full.
        send_beat(add_stop(stop_grid[5], 32'h8040_2010), pick_gap(), 1'b0);
        send_beat(add_stop(stop_grid[1], 32'h1122_3344), pick_gap(), 1'b0);
        send_beat(add_stop(16'sh0001, 32'hDEAD_BEEF), pick_gap(), 1'b0);
        send_beat(add_stop(stop_grid[5], 32'hA5A5_5A5A), pick_gap(), 1'b0);
        // Let the directed results drain before going random.
        send_beat(color_at(16'sh1800), 0, 1'b1);

        // Random part: mostly lookups; adds split between replaces and dropped new stops.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Every fourth stretch of 50 beats runs back to back.
            gap   = ((n / 50) % 4 == 1) ? 0 : pick_gap();
            drain = (n % 200 == 199);
            roll  = $urandom_range(0, 99);
            if (roll < 70) begin
                send_beat(color_at(pick_lookup()), gap, drain);
            end else if (roll < 85) begin
                send_beat(add_stop(stop_grid[$urandom_range(0, 7)], $urandom), gap, drain);
            end else begin
                send_beat(add_stop(int'($signed(16'($urandom))), $urandom), gap, drain);
            end
        end
        // Drop start if the last beat left it high, then drain and watch for strays.
        if (start) start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("color_gradient_lookup verification clean");
        end else begin
            $display("color_gradient_lookup verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #WATCHDOG_NS;
        $display("color_gradient_lookup verification failed");
        $finish;
    end

endmodule
